// File: hw/rtl/tlqs_pkg.sv
// ----------------------------------------------------------------------------
// Three-level queue scheduler package
// Shared widths, item codes, status codes and the sequencer microprogram.
// ----------------------------------------------------------------------------
package tlqs_pkg;

  // Default depth of each of the three queues.
  localparam int QUEUE_DEPTH_DEF = 16;

  // Payload widths.
  localparam int FUNC_W   = 2;
  localparam int SEL_W    = 2;
  localparam int BURST_W  = 4;
  localparam int MODE_W   = 2;
  localparam int BUDGET_W = 7;
  localparam int STATUS_W = 2;
  localparam int TICKS_W  = 7;
  localparam int FILLO_W  = 5;
  localparam int QIDX_W   = 2;

  // Request kinds.
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  // Run modes.
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SLICE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Sequencer steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [STEP_W-1:0] ST_DISPATCH = 4'd1;
  localparam logic [STEP_W-1:0] ST_ADD      = 4'd2;
  localparam logic [STEP_W-1:0] ST_REMOVE   = 4'd3;
  localparam logic [STEP_W-1:0] ST_SETUP    = 4'd4;
  localparam logic [STEP_W-1:0] ST_CHECK    = 4'd5;
  localparam logic [STEP_W-1:0] ST_TICK     = 4'd6;
  localparam logic [STEP_W-1:0] ST_NEXTQ    = 4'd7;
  localparam logic [STEP_W-1:0] ST_DONE     = 4'd8;

  // Datapath operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_LATCH  = 3'd0;
  localparam logic [OP_W-1:0] OP_NOP    = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_SETUP  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ   = 3'd5;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd6;
  localparam logic [OP_W-1:0] OP_NEXTQ  = 3'd7;

  // Jump conditions. A true condition selects the target, else the alternate.
  // The dispatch condition adds the request kind to the target.
  localparam int COND_W = 3;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd0;
  localparam logic [COND_W-1:0] COND_ACCEPT   = 3'd1;
  localparam logic [COND_W-1:0] COND_DISPATCH = 3'd2;
  localparam logic [COND_W-1:0] COND_MODE_BAD = 3'd3;
  localparam logic [COND_W-1:0] COND_SERVED   = 3'd4;
  localparam logic [COND_W-1:0] COND_STAY     = 3'd5;
  localparam logic [COND_W-1:0] COND_LAST_Q   = 3'd6;
  localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd7;

  // One control word of the microprogram.
  typedef struct packed {
    logic              ready;
    logic              emit;
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] tgt;
    logic [STEP_W-1:0] alt;
  } uword_t;

  // Microprogram store.
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{ready: 1'b0, emit: 1'b0, op: OP_NOP, cond: COND_ALWAYS,
          tgt: ST_IDLE, alt: ST_IDLE};
    case (step)
      ST_IDLE: begin
        w = '{1'b1, 1'b0, OP_LATCH, COND_ACCEPT, ST_DISPATCH, ST_IDLE};
      end
      ST_DISPATCH: begin
        w = '{1'b0, 1'b0, OP_NOP, COND_DISPATCH, ST_ADD, ST_DONE};
      end
      ST_ADD: begin
        w = '{1'b0, 1'b0, OP_ADD, COND_ALWAYS, ST_DONE, ST_DONE};
      end
      ST_REMOVE: begin
        w = '{1'b0, 1'b0, OP_REMOVE, COND_ALWAYS, ST_DONE, ST_DONE};
      end
      ST_SETUP: begin
        w = '{1'b0, 1'b0, OP_SETUP, COND_MODE_BAD, ST_DONE, ST_CHECK};
      end
      ST_CHECK: begin
        w = '{1'b0, 1'b0, OP_READ, COND_SERVED, ST_NEXTQ, ST_TICK};
      end
      ST_TICK: begin
        w = '{1'b0, 1'b0, OP_TICK, COND_STAY, ST_TICK, ST_CHECK};
      end
      ST_NEXTQ: begin
        w = '{1'b0, 1'b0, OP_NEXTQ, COND_LAST_Q, ST_DONE, ST_CHECK};
      end
      ST_DONE: begin
        w = '{1'b0, 1'b1, OP_NOP, COND_OUT_FREE, ST_IDLE, ST_DONE};
      end
      default: begin
        w = '{1'b0, 1'b0, OP_NOP, COND_ALWAYS, ST_IDLE, ST_IDLE};
      end
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/tlqs_in_if.sv
// ----------------------------------------------------------------------------
// Three-level queue scheduler request channel
// Valid/ready channel that carries one add, remove or run request.
// ----------------------------------------------------------------------------
interface tlqs_in_if
  import tlqs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SEL_W-1:0]    queue_select;
  logic [BURST_W-1:0]  burst;
  logic [MODE_W-1:0]   run_mode;
  logic [BUDGET_W-1:0] run_budget;

  modport source (
    output valid, func, queue_select, burst, run_mode, run_budget,
    input  ready
  );

  modport sink (
    input  valid, func, queue_select, burst, run_mode, run_budget,
    output ready
  );
endinterface

// File: hw/rtl/tlqs_out_if.sv
// ----------------------------------------------------------------------------
// Three-level queue scheduler result channel
// Valid/ready channel that carries the status, ticks and fills of a request.
// ----------------------------------------------------------------------------
interface tlqs_out_if
  import tlqs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TICKS_W-1:0]  ticks_first;
  logic [TICKS_W-1:0]  ticks_second;
  logic [TICKS_W-1:0]  ticks_third;
  logic [FILLO_W-1:0]  fill_first;
  logic [FILLO_W-1:0]  fill_second;
  logic [FILLO_W-1:0]  fill_third;

  modport source (
    output valid, status, ticks_first, ticks_second, ticks_third,
           fill_first, fill_second, fill_third,
    input  ready
  );

  modport sink (
    input  valid, status, ticks_first, ticks_second, ticks_third,
           fill_first, fill_second, fill_third,
    output ready
  );
endinterface

// File: hw/rtl/three_level_queue_scheduler_core.sv
// Flow: add and remove requests pass through the dispatch step and the add or
// remove step to the done step, which loads the result register; a run spends
// its ticks and pops zero entries in the check and tick steps (one tick per cycle).
// Throughput: one request at a time; a new request is taken once the previous
// result is in the output register, even if that result is not yet taken.
// Reset: synchronous active-low rst_n empties all three queues.
// ----------------------------------------------------------------------------
// Three-level queue scheduler core
// Microcoded sequencer over three circular FIFOs of remaining burst counts
// kept in one store, with fixed-priority and time-sliced run requests.
// ----------------------------------------------------------------------------
module three_level_queue_scheduler_core
  import tlqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tlqs_in_if.sink     in_ch,
  tlqs_out_if.source  out_ch
);

  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = PTR_W + 1;
  localparam int STORE_DEPTH = 3 * (2 ** PTR_W);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Sequencer state.
  logic [STEP_W-1:0]   step_r, step_nxt;
  uword_t              uw;

  // Latched request.
  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [SEL_W-1:0]    sel_r, sel_nxt;
  logic [BURST_W-1:0]  burst_r, burst_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [BUDGET_W-1:0] budget_in_r, budget_in_nxt;

  // Run datapath.
  logic [QIDX_W-1:0]   run_q_r, run_q_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [BUDGET_W-1:0] spent_r, spent_nxt;
  logic [BUDGET_W-1:0] slice2_r, slice2_nxt;
  logic [BUDGET_W-1:0] slice3_r, slice3_nxt;
  logic [BURST_W-1:0]  front_r, front_nxt;
  logic                fresh_r, fresh_nxt;
  logic [TICKS_W-1:0]  ticks_r [3];
  logic [TICKS_W-1:0]  ticks_nxt [3];
  logic [STATUS_W-1:0] status_r, status_nxt;

  // Queue bookkeeping.
  logic [PTR_W-1:0]    head_r [3];
  logic [PTR_W-1:0]    head_nxt [3];
  logic [FILL_W-1:0]   fill_r [3];
  logic [FILL_W-1:0]   fill_nxt [3];

  // Store ports.
  logic [BURST_W-1:0]  store_mem [STORE_DEPTH];
  logic [BURST_W-1:0]  rdata_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [BURST_W-1:0]  wr_data;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [TICKS_W-1:0]  out_ticks_r [3];
  logic [FILLO_W-1:0]  out_fill_r [3];

  // Helper values.
  logic                accept;
  logic                out_free;
  logic [QIDX_W-1:0]   sel_q;
  logic [QIDX_W-1:0]   act_q;
  logic [SUM_W-1:0]    tail_sum;
  logic [PTR_W-1:0]    tail_ptr;
  logic [PTR_W-1:0]    head_inc;
  logic                served;
  logic [BURST_W-1:0]  front_val;
  logic [BUDGET_W-1:0] half;
  logic [BUDGET_W-1:0] rest;
  logic                cond_hit;

  function automatic logic [BUDGET_W-1:0] in_budget_half(input logic [BUDGET_W-1:0] b);
    return b >> 1;
  endfunction

  assign uw        = ucode_rom(step_r);
  assign accept    = in_ch.valid && uw.ready && rst_n;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Queue addressed by the current step: the selected one for add and remove.
  assign sel_q     = (sel_r == '0) ? '0 : QIDX_W'(sel_r - SEL_W'(1));
  assign act_q     = (step_r == ST_ADD || step_r == ST_REMOVE) ? sel_q : run_q_r;
  assign tail_sum  = SUM_W'(head_r[act_q]) + SUM_W'(fill_r[act_q]);
  assign tail_ptr  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc  = (head_r[act_q] == PTR_W'(QUEUE_DEPTH - 1)) ?
                     '0 : PTR_W'(head_r[act_q] + PTR_W'(1));
  assign served    = (fill_r[run_q_r] == '0) || (spent_r >= budget_r);
  assign front_val = fresh_r ? rdata_r : front_r;
  assign rd_addr   = {run_q_r, head_r[run_q_r]};

  // Slice split for time slicing.
  assign half      = in_budget_half(budget_in_r);
  assign rest      = budget_in_r - half;

  // Jump condition of the current control word.
  always_comb begin
    case (uw.cond)
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_ACCEPT:   cond_hit = accept;
      COND_DISPATCH: cond_hit = (func_r != FUNC_NONE);
      COND_MODE_BAD: cond_hit = (mode_r != MODE_FIXED) && (mode_r != MODE_SLICE);
      COND_SERVED:   cond_hit = served;
      COND_STAY:     cond_hit = !served && (front_val != '0);
      COND_LAST_Q:   cond_hit = (run_q_r == QIDX_W'(2));
      COND_OUT_FREE: cond_hit = out_free;
      default:       cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    if (uw.cond == COND_DISPATCH && cond_hit) begin
      step_nxt = uw.tgt + STEP_W'(func_r);
    end else if (cond_hit) begin
      step_nxt = uw.tgt;
    end else begin
      step_nxt = uw.alt;
    end
  end

  // Datapath driven by the control word.
  always_comb begin
    func_nxt      = func_r;
    sel_nxt       = sel_r;
    burst_nxt     = burst_r;
    mode_nxt      = mode_r;
    budget_in_nxt = budget_in_r;
    run_q_nxt     = run_q_r;
    budget_nxt    = budget_r;
    spent_nxt     = spent_r;
    slice2_nxt    = slice2_r;
    slice3_nxt    = slice3_r;
    front_nxt     = front_r;
    fresh_nxt     = fresh_r;
    status_nxt    = status_r;
    ticks_nxt     = ticks_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    wr_en         = 1'b0;
    wr_addr       = {act_q, tail_ptr};
    wr_data       = burst_r;

    case (uw.op)
      // Capture a new request and clear its result fields.
      OP_LATCH: begin
        if (accept) begin
          func_nxt      = in_ch.func;
          sel_nxt       = in_ch.queue_select;
          burst_nxt     = in_ch.burst;
          mode_nxt      = in_ch.run_mode;
          budget_in_nxt = in_ch.run_budget;
          status_nxt    = STATUS_OK;
          ticks_nxt     = '{default: '0};
        end
      end
      // Push at the tail unless the queue is full.
      OP_ADD: begin
        if (sel_r != '0) begin
          if (fill_r[act_q] == FILL_W'(QUEUE_DEPTH)) begin
            status_nxt = STATUS_FULL;
          end else begin
            wr_en           = 1'b1;
            fill_nxt[act_q] = fill_r[act_q] + FILL_W'(1);
          end
        end
      end
      // Pop the front unless the queue is empty.
      OP_REMOVE: begin
        if (sel_r != '0) begin
          if (fill_r[act_q] == '0) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            head_nxt[act_q] = head_inc;
            fill_nxt[act_q] = fill_r[act_q] - FILL_W'(1);
          end
        end
      end
      // Start a run on queue 1 with its budget.
      OP_SETUP: begin
        run_q_nxt  = '0;
        spent_nxt  = '0;
        slice3_nxt = rest >> 1;
        slice2_nxt = rest - (rest >> 1);
        budget_nxt = (mode_r == MODE_FIXED) ? budget_in_r : half;
      end
      // The store read of the front is issued every cycle; mark it fresh.
      OP_READ: begin
        fresh_nxt = 1'b1;
      end
      // Spend one tick on a nonzero front, or pop a zero front.
      OP_TICK: begin
        if (!served) begin
          if (front_val != '0) begin
            wr_en     = 1'b1;
            wr_addr   = {run_q_r, head_r[run_q_r]};
            wr_data   = front_val - BURST_W'(1);
            front_nxt = front_val - BURST_W'(1);
            fresh_nxt = 1'b0;
            spent_nxt = spent_r + BUDGET_W'(1);
          end else begin
            head_nxt[run_q_r] = head_inc;
            fill_nxt[run_q_r] = fill_r[run_q_r] - FILL_W'(1);
          end
        end
      end
      // Record the ticks of this queue and move on to the next one.
      OP_NEXTQ: begin
        ticks_nxt[run_q_r] = TICKS_W'(spent_r);
        spent_nxt          = '0;
        if (mode_r == MODE_FIXED) begin
          budget_nxt = budget_r - spent_r;
        end else if (run_q_r == '0) begin
          budget_nxt = slice2_r;
        end else begin
          budget_nxt = slice3_r;
        end
        run_q_nxt = (run_q_r == QIDX_W'(2)) ? '0 : run_q_r + QIDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (uw.emit && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      run_q_r     <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '{default: '0};
      fill_r      <= '{default: '0};
      fresh_r     <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      run_q_r     <= run_q_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      fresh_r     <= fresh_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    sel_r       <= sel_nxt;
    burst_r     <= burst_nxt;
    mode_r      <= mode_nxt;
    budget_in_r <= budget_in_nxt;
    budget_r    <= budget_nxt;
    spent_r     <= spent_nxt;
    slice2_r    <= slice2_nxt;
    slice3_r    <= slice3_nxt;
    front_r     <= front_nxt;
    status_r    <= status_nxt;
    ticks_r     <= ticks_nxt;
    if (uw.emit && out_free) begin
      out_status_r  <= status_r;
      out_ticks_r   <= ticks_r;
      out_fill_r[0] <= FILLO_W'(fill_r[0]);
      out_fill_r[1] <= FILLO_W'(fill_r[1]);
      out_fill_r[2] <= FILLO_W'(fill_r[2]);
    end
  end

  // Entry store with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    rdata_r <= store_mem[rd_addr];
  end

  assign in_ch.ready         = uw.ready && rst_n;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.ticks_first  = out_ticks_r[0];
  assign out_ch.ticks_second = out_ticks_r[1];
  assign out_ch.ticks_third  = out_ticks_r[2];
  assign out_ch.fill_first   = out_fill_r[0];
  assign out_ch.fill_second  = out_fill_r[1];
  assign out_ch.fill_third   = out_fill_r[2];

  // No queue ever holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[0] <= FILL_W'(QUEUE_DEPTH)) && (fill_r[1] <= FILL_W'(QUEUE_DEPTH)) &&
    (fill_r[2] <= FILL_W'(QUEUE_DEPTH)))
    else $error("queue fill count exceeds depth");

  // A run never spends more than the budget of the queue being served.
  a_spent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_CHECK || step_r == ST_TICK || step_r == ST_NEXTQ) |->
      (spent_r <= budget_r))
    else $error("ticks spent exceed queue budget");

  // Leaving the done step always leaves a result in the output register.
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_DONE && step_nxt == ST_IDLE) |=> out_valid_r)
    else $error("result not registered when request finished");

  // A tick only decrements a nonzero front entry.
  a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_TICK && wr_en) |-> (front_val != '0))
    else $error("tick spent on a zero front entry");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Three-level queue scheduler testbench
// Sends add, remove and run requests through the request channel while both
// sides idle at random. A shadow copy of the three burst FIFOs predicts every
// result, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb
  import tlqs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CALM_TAIL    = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 300;

  // Segment flavors for the random part.
  localparam int SEG_FILL  = 0;
  localparam int SEG_MIX   = 1;
  localparam int SEG_DRAIN = 2;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [SEL_W-1:0]    queue_select;
    logic [BURST_W-1:0]  burst;
    logic [MODE_W-1:0]   run_mode;
    logic [BUDGET_W-1:0] run_budget;
  } sched_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [TICKS_W-1:0]  ticks_first;
    logic [TICKS_W-1:0]  ticks_second;
    logic [TICKS_W-1:0]  ticks_third;
    logic [FILLO_W-1:0]  fill_first;
    logic [FILLO_W-1:0]  fill_second;
    logic [FILLO_W-1:0]  fill_third;
  } sched_outcome_t;

  logic clk = 1'b0;
  logic rst_n;

  tlqs_in_if  in_ch ();
  tlqs_out_if out_ch ();

  three_level_queue_scheduler_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sched_req_t     request_q[$];
  sched_outcome_t outcome_q[$];
  sched_req_t     cur_req;
  int             errors = 0;
  int             accepted_count = 0;
  int             send_gap = 0;
  int             sink_gap = 0;
  logic           calm = 1'b0;
  logic           hold_off = 1'b0;

  // Shadow copy of the three burst FIFOs.
  logic [BURST_W-1:0] shadow_store [3][QDEPTH];
  int unsigned        shadow_head [3];
  int unsigned        shadow_fill [3];

  function automatic void drop_front(int q);
    shadow_head[q] = (shadow_head[q] + 1) % QDEPTH;
    shadow_fill[q]--;
  endfunction

  // Spend up to allowance ticks on queue q; zero fronts pop for free.
  function automatic int unsigned drain_queue(int q, int unsigned allowance);
    int unsigned used;
    used = 0;
    while (shadow_fill[q] > 0 && used < allowance) begin
      if (shadow_store[q][shadow_head[q]] != '0) begin
        shadow_store[q][shadow_head[q]] = shadow_store[q][shadow_head[q]] - 1'b1;
        used++;
      end else begin
        drop_front(q);
      end
    end
    return used;
  endfunction

  // Apply one request to the shadow queues and return its expected result.
  function automatic sched_outcome_t predict_outcome(sched_req_t r);
    sched_outcome_t o;
    int             q;
    int unsigned    left;
    int unsigned    s1;
    int unsigned    s2;
    int unsigned    s3;
    int unsigned    rest;
    int unsigned    spent [3];
    o = '{default: '0};
    spent = '{0, 0, 0};
    q = int'(r.queue_select) - 1;
    case (r.func)
      FUNC_ADD: begin
        if (r.queue_select != '0) begin
          if (shadow_fill[q] >= QDEPTH) begin
            o.status = STATUS_FULL;
          end else begin
            shadow_store[q][(shadow_head[q] + shadow_fill[q]) % QDEPTH] = r.burst;
            shadow_fill[q]++;
          end
        end
      end
      FUNC_REMOVE: begin
        if (r.queue_select != '0) begin
          if (shadow_fill[q] == 0) begin
            o.status = STATUS_EMPTY;
          end else begin
            drop_front(q);
          end
        end
      end
      FUNC_RUN: begin
        if (r.run_mode == MODE_FIXED) begin
          left = r.run_budget;
          for (int k = 0; k < 3; k++) begin
            spent[k] = drain_queue(k, left);
            left -= spent[k];
          end
        end else if (r.run_mode == MODE_SLICE) begin
          s1 = r.run_budget / 2;
          rest = r.run_budget - s1;
          s3 = rest / 2;
          s2 = rest - s3;
          spent[0] = drain_queue(0, s1);
          spent[1] = drain_queue(1, s2);
          spent[2] = drain_queue(2, s3);
        end
      end
      default: begin
      end
    endcase
    o.ticks_first  = TICKS_W'(spent[0]);
    o.ticks_second = TICKS_W'(spent[1]);
    o.ticks_third  = TICKS_W'(spent[2]);
    o.fill_first   = FILLO_W'(shadow_fill[0]);
    o.fill_second  = FILLO_W'(shadow_fill[1]);
    o.fill_third   = FILLO_W'(shadow_fill[2]);
    return o;
  endfunction

  function automatic sched_req_t mk_req(logic [FUNC_W-1:0] f, int sel, int b, int m, int bud);
    sched_req_t r;
    r.func         = f;
    r.queue_select = SEL_W'(sel);
    r.burst        = BURST_W'(b);
    r.run_mode     = MODE_W'(m);
    r.run_budget   = BUDGET_W'(bud);
    return r;
  endfunction

  // Random request; the segment flavor biases the mix of request kinds.
  function automatic sched_req_t make_request(int flavor, int focus);
    sched_req_t  r;
    int unsigned roll;
    int unsigned add_w;
    int unsigned rem_w;
    case (flavor)
      SEG_FILL: begin
        add_w = 85;
        rem_w = 5;
      end
      SEG_DRAIN: begin
        add_w = 15;
        rem_w = 30;
      end
      default: begin
        add_w = 45;
        rem_w = 20;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      r.func = FUNC_NONE;
    end else if (roll < 2 + add_w) begin
      r.func = FUNC_ADD;
    end else if (roll < 2 + add_w + rem_w) begin
      r.func = FUNC_REMOVE;
    end else begin
      r.func = FUNC_RUN;
    end
    if ($urandom_range(0, 19) == 0) begin
      r.queue_select = SEL_W'($urandom_range(0, 3));
    end else if ($urandom_range(0, 9) < 7) begin
      r.queue_select = SEL_W'(focus);
    end else begin
      r.queue_select = SEL_W'($urandom_range(1, 3));
    end
    if ($urandom_range(0, 99) < 85) begin
      r.burst = BURST_W'($urandom_range(1, 9));
    end else begin
      r.burst = BURST_W'($urandom_range(0, 15));
    end
    if ($urandom_range(0, 9) != 0) begin
      r.run_mode = $urandom_range(0, 1) ? MODE_FIXED : MODE_SLICE;
    end else begin
      r.run_mode = MODE_W'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 99) < 85) begin
      r.run_budget = BUDGET_W'($urandom_range(1, 99));
    end else begin
      r.run_budget = BUDGET_W'($urandom_range(0, 127));
    end
    return r;
  endfunction

  function automatic string show_outcome(sched_outcome_t o);
    return $sformatf("st=%0d t=%0d/%0d/%0d fill=%0d/%0d/%0d", o.status, o.ticks_first,
                     o.ticks_second, o.ticks_third, o.fill_first, o.fill_second,
                     o.fill_third);
  endfunction

  // Driver: offers pending requests and records each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      calm <= (request_q.size() < CALM_TAIL);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_ch.valid) begin
          outcome_q.push_back(predict_outcome(cur_req));
          accepted_count++;
        end
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.func         <= cur_req.func;
          in_ch.queue_select <= cur_req.queue_select;
          in_ch.burst        <= cur_req.burst;
          in_ch.run_mode     <= cur_req.run_mode;
          in_ch.run_budget   <= cur_req.run_budget;
          if (!calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 9);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    sched_outcome_t got;
    sched_outcome_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.ticks_first, out_ch.ticks_second, out_ch.ticks_third,
                out_ch.fill_first, out_ch.fill_second, out_ch.fill_third};
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: got %s", $time, show_outcome(got));
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status || got.ticks_first !== want.ticks_first ||
              got.ticks_second !== want.ticks_second ||
              got.ticks_third !== want.ticks_third ||
              got.fill_first !== want.fill_first || got.fill_second !== want.fill_second ||
              got.fill_third !== want.fill_third) begin
            errors++;
            $display("%0t: mismatch: expected %s, got %s", $time, show_outcome(want),
                     show_outcome(got));
          end
        end
      end
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) begin
          sink_gap = $urandom_range(1, 9);
        end
      end
    end
  end

  // Long receiver stall so the block backs up and refuses requests.
  initial begin
    wait (accepted_count >= 400);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int flavor;
    int focus;
    int seg_len;
    int target;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_NONE;
    in_ch.queue_select = '0;
    in_ch.burst = '0;
    in_ch.run_mode = '0;
    in_ch.run_budget = '0;
    out_ch.ready = 1'b0;
    for (int q = 0; q < 3; q++) begin
      shadow_head[q] = 0;
      shadow_fill[q] = 0;
    end

    // Directed: empty queues, field extremes, odd selects, modes and budgets.
    request_q.push_back(mk_req(FUNC_REMOVE, 1, 3, 1, 10));
    request_q.push_back(mk_req(FUNC_RUN, 2, 0, MODE_FIXED, 50));
    request_q.push_back(mk_req(FUNC_ADD, 1, 9, 0, 0));
    request_q.push_back(mk_req(FUNC_ADD, 1, 1, 3, 127));
    request_q.push_back(mk_req(FUNC_ADD, 2, 15, 1, 5));
    request_q.push_back(mk_req(FUNC_ADD, 2, 0, 2, 99));
    request_q.push_back(mk_req(FUNC_ADD, 3, 9, 1, 1));
    request_q.push_back(mk_req(FUNC_ADD, 3, 0, 0, 64));
    request_q.push_back(mk_req(FUNC_ADD, 0, 5, 1, 20));
    request_q.push_back(mk_req(FUNC_REMOVE, 0, 5, 1, 20));
    request_q.push_back(mk_req(FUNC_NONE, 1, 7, MODE_FIXED, 127));
    request_q.push_back(mk_req(FUNC_RUN, 1, 2, 0, 127));
    request_q.push_back(mk_req(FUNC_RUN, 3, 2, 3, 127));
    request_q.push_back(mk_req(FUNC_RUN, 1, 0, MODE_SLICE, 0));
    request_q.push_back(mk_req(FUNC_RUN, 1, 0, MODE_SLICE, 1));
    request_q.push_back(mk_req(FUNC_RUN, 1, 0, MODE_SLICE, 7));
    request_q.push_back(mk_req(FUNC_RUN, 1, 0, MODE_FIXED, 127));
    request_q.push_back(mk_req(FUNC_ADD, 1, 5, 0, 0));
    request_q.push_back(mk_req(FUNC_ADD, 2, 3, 0, 0));
    request_q.push_back(mk_req(FUNC_RUN, 1, 0, MODE_SLICE, 127));
    request_q.push_back(mk_req(FUNC_REMOVE, 3, 0, 0, 0));
    request_q.push_back(mk_req(FUNC_REMOVE, 2, 0, 0, 0));

    // Random segments: fill bursts to reach full queues, mixed traffic, drains.
    target = request_q.size() + RANDOM_ITEMS;
    while (request_q.size() < target) begin
      flavor = $urandom_range(SEG_FILL, SEG_DRAIN);
      focus = $urandom_range(1, 3);
      seg_len = (flavor == SEG_FILL) ? $urandom_range(10, 30) : $urandom_range(5, 40);
      for (int i = 0; i < seg_len; i++) begin
        request_q.push_back(make_request(flavor, focus));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_ch.valid) @(negedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tlqs_pkg.sv
hw/rtl/tlqs_in_if.sv
hw/rtl/tlqs_out_if.sv
hw/rtl/three_level_queue_scheduler_core.sv
verif/tb.sv
